@@ rtl/cht_pkg.sv @@
// Package with shared constants, status codes and request/result types.
`default_nettype none

package cht_pkg;

  // Default sizes of the table.
  localparam int unsigned MAP_COUNT_DEF    = 8;
  localparam int unsigned BUCKET_COUNT_DEF = 32;
  localparam int unsigned POOL_ENTRIES_DEF = 256;
  localparam int unsigned VALUE_BITS_DEF   = 32;

  // Fixed field widths.
  localparam int unsigned HASH_W   = 32;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned MAP_ID_W = 3;
  localparam int unsigned STAT_W   = 2;

  // Result status codes.
  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd1;
  localparam logic [STAT_W-1:0] ST_DROP = 2'd2;

  // Operation codes.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // One table operation, handed to the walker with the final key byte.
  typedef struct packed {
    logic                cmd;
    logic [MAP_ID_W-1:0] map_id;
    logic [DATA_W-1:0]   value;
    logic [HASH_W-1:0]   hash;
  } req_t;

  // One result word.
  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] value_out;
    logic [HASH_W-1:0] hash_code;
  } res_t;

endpackage

`default_nettype wire

@@ rtl/cht_ifs.sv @@
// Valid/ready channel interfaces for key bytes and for results.
`default_nettype none

interface cht_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [2:0]  map_id;
  logic [7:0]  key_byte;
  logic        key_last;
  logic [31:0] value;

  modport source (output valid, cmd, map_id, key_byte, key_last, value, input ready);
  modport sink (input valid, cmd, map_id, key_byte, key_last, value, output ready);
endinterface

interface cht_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] value_out;
  logic [31:0] hash_code;

  modport source (output valid, status, value_out, hash_code, input ready);
  modport sink (input valid, status, value_out, hash_code, output ready);
endinterface

`default_nettype wire

@@ rtl/cht_ram.sv @@
// Simple dual-port synchronous RAM with one write port and a registered read port.
`default_nettype none

module cht_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

@@ rtl/cht_hash.sv @@
// Running string hash (h = 31*h + byte) with end-of-key mixing.
`default_nettype none

module cht_hash import cht_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              take,
  input  wire logic [7:0]        key_byte,
  input  wire logic              key_last,
  output logic      [HASH_W-1:0] mix_hash
);

  logic [HASH_W-1:0] accum_r;
  logic              ended_r;
  logic [HASH_W-1:0] fold;

  // Fold the current byte into the hash unless it is zero or the key already ended.
  always_comb begin
    if (ended_r || (key_byte == 8'd0)) begin
      fold = accum_r;
    end else begin
      fold = (accum_r << 5) - accum_r + HASH_W'(key_byte);
    end
    mix_hash = fold ^ (fold >> 16);
  end

  // The final word of a key returns the hash state to its start.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      ended_r <= 1'b0;
    end else if (take) begin
      if (key_last) begin
        accum_r <= '0;
        ended_r <= 1'b0;
      end else begin
        accum_r <= fold;
        if (key_byte == 8'd0) begin
          ended_r <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/cht_walk.sv @@
// Table engine: head clearing, bucket selection, chain walk and node update.
`default_nettype none

module cht_walk import cht_pkg::*; #(
  parameter int unsigned MAP_COUNT    = MAP_COUNT_DEF,
  parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF,
  parameter int unsigned POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  input  wire req_t req,
  output logic      idle,
  input  wire logic out_free,
  output logic      res_load,
  output res_t      res
);

  localparam int unsigned HEAD_COUNT = MAP_COUNT * BUCKET_COUNT;
  localparam int unsigned HA_W   = $clog2(HEAD_COUNT);
  localparam int unsigned NA_W   = $clog2(POOL_ENTRIES);
  localparam int unsigned PTR_W  = $clog2(POOL_ENTRIES + 1);
  localparam int unsigned BK_W   = $clog2(BUCKET_COUNT);
  localparam int unsigned VW     = (VALUE_BITS < DATA_W) ? VALUE_BITS : DATA_W;
  localparam int unsigned NODE_W = HASH_W + VW + PTR_W;
  localparam int unsigned VAL_LO  = PTR_W;
  localparam int unsigned HASH_LO = PTR_W + VW;
  localparam bit          BKT_POW2 = (BUCKET_COUNT & (BUCKET_COUNT - 1)) == 0;
  localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(POOL_ENTRIES);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MOD   = 3'd2;
  localparam logic [2:0] S_HEAD  = 3'd3;
  localparam logic [2:0] S_FIRST = 3'd4;
  localparam logic [2:0] S_NODE  = 3'd5;
  localparam logic [2:0] S_LINK  = 3'd6;
  localparam logic [2:0] S_OUT   = 3'd7;

  logic [2:0]        state_r, state_nxt;
  logic [HASH_W-1:0] h_r, h_nxt;
  logic              cmd_r, cmd_nxt;
  logic [2:0]        map_r, map_nxt;
  logic [VW-1:0]     val_r, val_nxt;
  logic [BK_W-1:0]   rem_r, rem_nxt;
  logic [HASH_W-1:0] sh_r, sh_nxt;
  logic [2:0]        mcnt_r, mcnt_nxt;
  logic [NA_W-1:0]   cur_r, cur_nxt;
  logic [NA_W-1:0]   tail_r, tail_nxt;
  logic [NODE_W-1:0] tail_word_r, tail_word_nxt;
  logic [PTR_W-1:0]  new_r, new_nxt;
  logic [HA_W-1:0]   clr_cnt_r, clr_cnt_nxt;
  logic [PTR_W-1:0]  pool_used_r, pool_used_nxt;
  res_t              res_r, res_nxt;

  logic              head_we, head_re;
  logic [HA_W-1:0]   head_waddr;
  logic [PTR_W-1:0]  head_wdata, head_rdata;
  logic              node_we, node_re;
  logic [NA_W-1:0]   node_waddr, node_raddr;
  logic [NODE_W-1:0] node_wdata, node_rdata;

  logic [BK_W-1:0]   bkt;
  logic [HA_W-1:0]   slot;
  logic [HASH_W-1:0] nd_hash;
  logic [VW-1:0]     nd_val;
  logic [PTR_W-1:0]  nd_link;
  logic              pool_full;
  logic              fin, hit, tl_null;

  // Map number folded into the configured map count.
  function automatic logic [2:0] map_fold(input logic [2:0] id);
    int unsigned m;
    m = 32'(id);
    for (int i = 0; i < 8; i++) begin
      if (m >= MAP_COUNT) begin
        m = m - MAP_COUNT;
      end
    end
    return 3'(m);
  endfunction

  cht_ram #(.DEPTH(HEAD_COUNT), .WIDTH(PTR_W)) u_heads (
    .clk     (clk),
    .wr_en   (head_we),
    .wr_addr (head_waddr),
    .wr_data (head_wdata),
    .rd_en   (head_re),
    .rd_addr (slot),
    .rd_data (head_rdata)
  );

  cht_ram #(.DEPTH(POOL_ENTRIES), .WIDTH(NODE_W)) u_nodes (
    .clk     (clk),
    .wr_en   (node_we),
    .wr_addr (node_waddr),
    .wr_data (node_wdata),
    .rd_en   (node_re),
    .rd_addr (node_raddr),
    .rd_data (node_rdata)
  );

  // Fields of the node word just read, and the bucket address.
  assign nd_hash   = node_rdata[HASH_LO +: HASH_W];
  assign nd_val    = node_rdata[VAL_LO +: VW];
  assign nd_link   = node_rdata[PTR_W-1:0];
  assign bkt       = BKT_POW2 ? h_r[BK_W-1:0] : rem_r;
  assign slot      = HA_W'(32'(map_r) * BUCKET_COUNT) + HA_W'(bkt);
  assign pool_full = (pool_used_r == NULL_PTR);
  assign idle      = (state_r == S_IDLE);
  assign res       = res_r;

  // Sequencer. Operations never overlap, so every write lands before the
  // next operation issues its first read.
  always_comb begin
    logic [BK_W:0]     r;
    logic [HASH_W-1:0] s;

    state_nxt     = state_r;
    h_nxt         = h_r;
    cmd_nxt       = cmd_r;
    map_nxt       = map_r;
    val_nxt       = val_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    mcnt_nxt      = mcnt_r;
    cur_nxt       = cur_r;
    tail_nxt      = tail_r;
    tail_word_nxt = tail_word_r;
    new_nxt       = new_r;
    clr_cnt_nxt   = clr_cnt_r;
    pool_used_nxt = pool_used_r;
    res_nxt       = res_r;
    head_we       = 1'b0;
    head_re       = 1'b0;
    head_waddr    = slot;
    head_wdata    = NULL_PTR;
    node_we       = 1'b0;
    node_re       = 1'b0;
    node_waddr    = cur_r;
    node_wdata    = '0;
    node_raddr    = cur_r;
    res_load      = 1'b0;
    fin           = 1'b0;
    hit           = 1'b0;
    tl_null       = 1'b0;
    r             = '0;
    s             = sh_r;

    unique case (state_r)
      // Sweep every bucket head to empty after reset.
      S_CLEAR: begin
        head_we     = 1'b1;
        head_waddr  = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == HA_W'(HEAD_COUNT - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          h_nxt     = req.hash;
          cmd_nxt   = req.cmd;
          map_nxt   = map_fold(req.map_id);
          val_nxt   = VW'(req.value);
          rem_nxt   = '0;
          sh_nxt    = req.hash;
          mcnt_nxt  = '0;
          state_nxt = BKT_POW2 ? S_HEAD : S_MOD;
        end
      end
      // Bucket remainder, four hash bits per cycle, most significant first.
      S_MOD: begin
        r = {1'b0, rem_r};
        for (int i = 0; i < 4; i++) begin
          r = {r[BK_W-1:0], s[HASH_W-1]};
          s = s << 1;
          if (r >= (BK_W + 1)'(BUCKET_COUNT)) begin
            r = r - (BK_W + 1)'(BUCKET_COUNT);
          end
        end
        rem_nxt  = r[BK_W-1:0];
        sh_nxt   = s;
        mcnt_nxt = mcnt_r + 1'b1;
        if (mcnt_r == 3'd7) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        head_re   = 1'b1;
        state_nxt = S_FIRST;
      end
      // Head pointer arrives; start the walk or finish on an empty bucket.
      S_FIRST: begin
        if (head_rdata == NULL_PTR) begin
          fin     = 1'b1;
          tl_null = 1'b1;
        end else begin
          node_re    = 1'b1;
          node_raddr = head_rdata[NA_W-1:0];
          cur_nxt    = head_rdata[NA_W-1:0];
          state_nxt  = S_NODE;
        end
      end
      // One node per cycle: compare its hash, else follow its link.
      S_NODE: begin
        if (nd_hash == h_r) begin
          fin = 1'b1;
          hit = 1'b1;
        end else if (nd_link == NULL_PTR) begin
          fin = 1'b1;
        end else begin
          node_re    = 1'b1;
          node_raddr = nd_link[NA_W-1:0];
          cur_nxt    = nd_link[NA_W-1:0];
        end
      end
      // Hook the new node onto the old tail of the chain.
      S_LINK: begin
        node_we    = 1'b1;
        node_waddr = tail_r;
        node_wdata = {tail_word_r[NODE_W-1:PTR_W], new_r};
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // End of the walk: form the result and apply any update.
    if (fin) begin
      state_nxt         = S_OUT;
      res_nxt.hash_code = h_r;
      res_nxt.value_out = '0;
      res_nxt.status    = ST_OK;
      if (cmd_r == CMD_GET) begin
        if (hit) begin
          res_nxt.value_out = DATA_W'(nd_val);
        end else begin
          res_nxt.status = ST_MISS;
        end
      end else if (hit) begin
        node_we    = 1'b1;
        node_waddr = cur_r;
        node_wdata = {nd_hash, val_r, nd_link};
      end else if (pool_full) begin
        res_nxt.status = ST_DROP;
      end else begin
        node_we       = 1'b1;
        node_waddr    = pool_used_r[NA_W-1:0];
        node_wdata    = {h_r, val_r, NULL_PTR};
        pool_used_nxt = pool_used_r + 1'b1;
        if (tl_null) begin
          head_we    = 1'b1;
          head_waddr = slot;
          head_wdata = pool_used_r;
        end else begin
          tail_nxt      = cur_r;
          tail_word_nxt = node_rdata;
          new_nxt       = pool_used_r;
          state_nxt     = S_LINK;
        end
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      pool_used_r <= '0;
      mcnt_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      pool_used_r <= pool_used_nxt;
      mcnt_r      <= mcnt_nxt;
    end
  end

  // Operation payload.
  always_ff @(posedge clk) begin
    h_r         <= h_nxt;
    cmd_r       <= cmd_nxt;
    map_r       <= map_nxt;
    val_r       <= val_nxt;
    rem_r       <= rem_nxt;
    sh_r        <= sh_nxt;
    cur_r       <= cur_nxt;
    tail_r      <= tail_nxt;
    tail_word_r <= tail_word_nxt;
    new_r       <= new_nxt;
    res_r       <= res_nxt;
  end

`ifndef NO_ASSERTIONS
  // The walk only ever reads nodes that have been allocated.
  a_node_rd_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    node_re |-> (PTR_W'(node_raddr) < pool_used_r))
    else $error("node read beyond allocated pool");

  // Node writes touch allocated nodes or the next free one.
  a_node_wr_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    node_we |-> (PTR_W'(node_waddr) <= pool_used_r))
    else $error("node write beyond next free node");

  // Outside the clearing sweep a head changes only when a node is appended.
  a_head_wr_append: assert property (@(posedge clk) disable iff (!rst_n)
    (head_we && (state_r != S_CLEAR)) |-> (node_we && (head_wdata == pool_used_r)))
    else $error("bucket head written without a node append");

  // The pool count only grows, one node at a time.
  a_pool_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && (pool_used_r != $past(pool_used_r)))
      |-> (pool_used_r == $past(pool_used_r) + 1'b1))
    else $error("pool count changed by other than one");
`endif

endmodule

`default_nettype wire

@@ rtl/chained_hash_table_string_keys_core.sv @@
// Top level of the chained hash table with string keys.
`default_nettype none

// Key words arrive one per handshake; each word carries one byte of a key,
// the map number, the command and, with the final byte, the value to store.
// Bytes that are not final are folded into the hash as they are accepted. A
// final byte starts the table operation and the input is held off until it
// has finished: the walker reads the bucket head, walks the chain nodes, and
// when a put appends to a chain that is not empty links the old tail; when
// BUCKET_COUNT is not a power of two the bucket remainder is worked out
// first. The chain walk reads one node per cycle from the node memory; a
// put that appends writes the node and then the old tail's link through the
// single write port. One finished result may wait in the output register
// while the next key streams in. After reset a clearing pass over all
// MAP_COUNT*BUCKET_COUNT bucket heads empties them before the first
// word is accepted. Only full 32-bit hashes are compared, never key bytes.
module chained_hash_table_string_keys_core import cht_pkg::*; #(
  parameter int unsigned MAP_COUNT    = MAP_COUNT_DEF,
  parameter int unsigned BUCKET_COUNT = BUCKET_COUNT_DEF,
  parameter int unsigned POOL_ENTRIES = POOL_ENTRIES_DEF,
  parameter int unsigned VALUE_BITS   = VALUE_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  cht_in_if.sink   in_chan,
  cht_out_if.source out_chan
);

  logic              walk_idle;
  logic              in_take;
  logic              start;
  logic [HASH_W-1:0] mix_hash;
  req_t              req;
  logic              out_free;
  logic              res_load;
  res_t              walk_res;
  logic              out_valid_r;
  res_t              out_res_r;

  // Input handshake.
  assign in_chan.ready = walk_idle;
  assign in_take       = in_chan.valid && walk_idle;
  assign start         = in_take && in_chan.key_last;

  cht_hash u_hash (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (in_take),
    .key_byte (in_chan.key_byte),
    .key_last (in_chan.key_last),
    .mix_hash (mix_hash)
  );

  // Operation handed to the walker with the final byte.
  always_comb begin
    req.cmd    = in_chan.cmd;
    req.map_id = in_chan.map_id;
    req.value  = in_chan.value;
    req.hash   = mix_hash;
  end

  cht_walk #(
    .MAP_COUNT    (MAP_COUNT),
    .BUCKET_COUNT (BUCKET_COUNT),
    .POOL_ENTRIES (POOL_ENTRIES),
    .VALUE_BITS   (VALUE_BITS)
  ) u_walk (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req      (req),
    .idle     (walk_idle),
    .out_free (out_free),
    .res_load (res_load),
    .res      (walk_res)
  );

  // Output register; it frees up in the cycle its word is taken.
  assign out_free = !out_valid_r || out_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= walk_res;
    end
  end

  assign out_chan.valid     = out_valid_r;
  assign out_chan.status    = out_res_r.status;
  assign out_chan.value_out = out_res_r.value_out;
  assign out_chan.hash_code = out_res_r.hash_code;

endmodule

`default_nettype wire
